FILE: hdl/mhbs_pkg.sv
// ============================================================================
// mhbs_pkg
// Shared types and constants for the max Hamming basis selector: sequencer
// states, register indexes and parameter defaults.
// ============================================================================
`default_nettype none

package mhbs_pkg;

  // Parameter defaults
  localparam int MAX_ROWS_DEF  = 256;
  localparam int MAX_WORDS_DEF = 4;
  localparam int MAX_BASIS_DEF = 16;

  // Fixed field widths
  localparam int WORD_W   = 64;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int POP_W    = 7;

  // Register reset values
  localparam logic [8:0] NUM_ROWS_RST  = 9'd256;
  localparam logic [4:0] NUM_BASIS_RST = 5'd16;
  localparam logic [2:0] WORDS_RST     = 3'd4;

  // Input modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS  = 2'd0,
    REG_NUM_BASIS = 2'd1,
    REG_WORDS     = 2'd2
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_ROW,
    S_CHK,
    S_RD,
    S_POP,
    S_ACC,
    S_UPD,
    S_NEXT,
    S_MARK
  } sel_state_t;

endpackage

`default_nettype wire

FILE: hdl/max_hamming_basis_selector_core.sv
// ============================================================================
// max_hamming_basis_selector_core
// Greedy farthest-first row selection under summed Hamming distance.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): mode 0 writes one 64-bit row word into
//   the row store and gives no result. Mode 1 starts a selection from
//   first_index; in_ready stays low until the last result is queued.
//   Output channel (out_valid/out_ready): one item per chosen row, in order,
//   with last on the final one. A rejected start gives a single item with
//   error and last set.
//   The first result is loaded into the output register from the emit step
//   that follows the accepted start. Each further pick is one pass over the
//   rows in use, with read, popcount and accumulate steps per word of each
//   unchosen row and a mark step per pick. All words go through one shared
//   XOR/popcount/accumulate unit fed by a two-read-port row store.
//   A stalled receiver holds the output register; the sequencer then waits
//   in its queue step before the next pass.
//   Reset clears the sequencer and output valid, and restores the config
//   registers (256 rows, 16 basis rows, 4 words). The row store and the
//   per-row sums need no clearing pass: sums are taken as zero on the first
//   pass of each start. Configuration is written through cfg_wr_en/cfg_index/
//   cfg_data, by the user only while idle; the block does not enforce this.
// ============================================================================
`default_nettype none

module max_hamming_basis_selector_core #(
  parameter int MAX_ROWS  = mhbs_pkg::MAX_ROWS_DEF,
  parameter int MAX_WORDS = mhbs_pkg::MAX_WORDS_DEF,
  parameter int MAX_BASIS = mhbs_pkg::MAX_BASIS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_wr_en,
  input  wire logic [mhbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mhbs_pkg::CFG_W-1:0]           cfg_data,
  // input items
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 mode,
  input  wire logic [7:0]                           row_index,
  input  wire logic [1:0]                           word_index,
  input  wire logic [mhbs_pkg::WORD_W-1:0]          row_word,
  input  wire logic [7:0]                           first_index,
  // result items
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [7:0]                                selected_index,
  output logic [3:0]                                position,
  output logic                                      last,
  output logic                                      error
);
  import mhbs_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int WW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int AW    = $clog2(MAX_ROWS * MAX_WORDS);
  localparam int SW    = $clog2(MAX_BASIS * MAX_WORDS * WORD_W + 1);
  localparam int KW    = $clog2(MAX_BASIS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_WORDS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [8:0] num_rows;
  logic [4:0] num_basis;
  logic [2:0] words_per_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows      <= NUM_ROWS_RST;
      num_basis     <= NUM_BASIS_RST;
      words_per_row <= WORDS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUM_ROWS:  num_rows      <= cfg_data[8:0];
        REG_NUM_BASIS: num_basis     <= cfg_data[4:0];
        REG_WORDS:     words_per_row <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp rows and words to the capacity
  logic [15:0] rows_eff;
  logic [15:0] words_eff;
  logic [15:0] basis_ext;
  logic        start_bad;

  assign rows_eff  = (16'(num_rows) > 16'(MAX_ROWS)) ? 16'(MAX_ROWS) : 16'(num_rows);
  assign words_eff = (16'(words_per_row) > 16'(MAX_WORDS)) ? 16'(MAX_WORDS)
                                                           : 16'(words_per_row);
  assign basis_ext = 16'(num_basis);
  assign start_bad = (16'(first_index) >= rows_eff) || (basis_ext == 16'd0) ||
                     (basis_ext > rows_eff) || (basis_ext > 16'(MAX_BASIS));

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  sel_state_t     state, state_next;
  logic [RW-1:0]  row_ctr;
  logic [WW-1:0]  word_ctr;
  logic [RW-1:0]  pick_row;
  logic [RW-1:0]  first_row;
  logic           first_pass;
  logic [KW-1:0]  pick_pos;
  logic [SW-1:0]  sum_old;
  logic [SW-1:0]  acc;
  logic [POP_W-1:0] pop;
  logic [RW-1:0]  best_row;
  logic [SW-1:0]  best_distance;
  logic           best_valid;
  logic [7:0]     res_index;
  logic [3:0]     res_pos;
  logic           res_last;
  logic           res_err;

  logic           in_take;
  logic           out_free;
  logic           row_end;
  logic           word_end;
  logic [SW-1:0]  sum_new;
  logic           row_chosen;

  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign row_end  = (16'(row_ctr) == rows_eff - 16'd1);
  assign word_end = (16'(word_ctr) == words_eff - 16'd1);
  assign sum_new  = sum_old + acc;

  // --------------------------------------------------------------------------
  // Row store: one write port, two read ports (candidate and last pick)
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] row_store [DEPTH];
  logic [WORD_W-1:0] cand_word;
  logic [WORD_W-1:0] pick_word;
  logic [31:0]       load_addr;
  logic [31:0]       cand_addr;
  logic [31:0]       pick_addr;
  logic              load_ok;

  assign load_addr = 32'(row_index) * 32'(MAX_WORDS) + 32'(word_index);
  assign cand_addr = 32'(row_ctr) * 32'(MAX_WORDS) + 32'(word_ctr);
  assign pick_addr = 32'(pick_row) * 32'(MAX_WORDS) + 32'(word_ctr);
  assign load_ok   = (16'(row_index) < 16'(MAX_ROWS)) && (16'(word_index) < 16'(MAX_WORDS));

  always_ff @(posedge clk) begin
    if (in_take && mode == MODE_LOAD && load_ok) begin
      row_store[load_addr[AW-1:0]] <= row_word;
    end
    if (state == S_RD) begin
      cand_word <= row_store[cand_addr[AW-1:0]];
      pick_word <= row_store[pick_addr[AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Sum store: chosen flag and running distance sum per row
  // --------------------------------------------------------------------------
  logic [SW:0]   sum_store [MAX_ROWS];
  logic [SW:0]   sum_rdata;
  logic          sum_we;
  logic [RW-1:0] sum_waddr;
  logic [SW:0]   sum_wdata;

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = row_ctr;
    sum_wdata = {1'b0, sum_new};
    case (state)
      S_IDLE: begin
        sum_we    = in_take && mode == MODE_START && !start_bad;
        sum_waddr = RW'(first_index);
        sum_wdata = {1'b1, {SW{1'b0}}};
      end
      S_UPD: begin
        sum_we    = 1'b1;
      end
      S_MARK: begin
        sum_we    = 1'b1;
        sum_waddr = best_row;
        sum_wdata = {1'b1, best_distance};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_store[sum_waddr] <= sum_wdata;
    end
    if (state == S_ROW) begin
      sum_rdata <= sum_store[row_ctr];
    end
  end

  // A row's flag is stale on the first pass; only the first pick is chosen then
  assign row_chosen = first_pass ? (row_ctr == first_row) : sum_rdata[SW];

  // --------------------------------------------------------------------------
  // Popcount over one 64-bit word, as a log-depth tree of field sums
  // --------------------------------------------------------------------------
  function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] x;
    x = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    x = (x & 64'h3333_3333_3333_3333) + ((x >> 2) & 64'h3333_3333_3333_3333);
    x = (x + (x >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    x = x + (x >> 8);
    x = x + (x >> 16);
    x = x + (x >> 32);
    return x[POP_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // State register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && mode == MODE_START) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = res_last ? S_IDLE : S_ROW;
        end
      end
      S_ROW: state_next = S_CHK;
      S_CHK: begin
        if (row_chosen) begin
          state_next = S_NEXT;
        end else if (words_eff == 16'd0) begin
          state_next = S_UPD;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD:  state_next = S_POP;
      S_POP: state_next = S_ACC;
      S_ACC: state_next = word_end ? S_UPD : S_RD;
      S_UPD: state_next = S_NEXT;
      S_NEXT: state_next = row_end ? S_MARK : S_ROW;
      S_MARK: state_next = S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath: counters, shared accumulate, best tracking, pending result
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      first_pass <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take && mode == MODE_START) begin
            res_pos <= '0;
            res_err <= start_bad;
            if (start_bad) begin
              res_index <= '0;
              res_last  <= 1'b1;
            end else begin
              res_index  <= first_index;
              res_last   <= (num_basis == 5'd1);
              first_row  <= RW'(first_index);
              pick_row   <= RW'(first_index);
              pick_pos   <= KW'(1);
              first_pass <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          // start a fresh pass
          row_ctr    <= '0;
          best_valid <= 1'b0;
        end
        S_CHK: begin
          sum_old  <= first_pass ? '0 : sum_rdata[SW-1:0];
          acc      <= '0;
          word_ctr <= '0;
        end
        S_POP: begin
          pop <= popcount(cand_word ^ pick_word);
        end
        S_ACC: begin
          acc      <= acc + SW'(pop);
          word_ctr <= word_ctr + WW'(1);
        end
        S_UPD: begin
          if (!best_valid || sum_new > best_distance) begin
            best_valid    <= 1'b1;
            best_row      <= row_ctr;
            best_distance <= sum_new;
          end
        end
        S_NEXT: begin
          row_ctr <= row_ctr + RW'(1);
        end
        S_MARK: begin
          pick_row   <= best_row;
          res_index  <= 8'(best_row);
          res_pos    <= 4'(pick_pos);
          res_last   <= (16'(pick_pos) + 16'd1 == basis_ext);
          res_err    <= 1'b0;
          pick_pos   <= pick_pos + KW'(1);
          first_pass <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      selected_index <= res_index;
      position       <= res_pos;
      last           <= res_last;
      error          <= res_err;
    end
  end

`ifndef NO_ASSERTIONS
  // After a start item is taken, the input channel is not ready in the next cycle
  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode == MODE_START) |=> !in_ready)
    else $error("input accepted right after a start item");

  // A rejected start is a single final item at index zero
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (last && selected_index == 8'd0 && position == 4'd0))
    else $error("error item malformed");

  // The word counter never runs past the row width
  a_word_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (16'(word_ctr) < words_eff))
    else $error("word counter out of range");

  // Every pass finds a candidate before marking it
  a_pick_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> best_valid)
    else $error("pass ended without a candidate");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_max_hamming_basis_selector_core.sv
// ----------------------------------------------------------------------------
// tb_max_hamming_basis_selector_core
// Self-checking bench for the greedy max Hamming basis selector. The bench
// first fills every word of the low rows, then runs directed starts over the
// corner settings. After that it runs random phases of row loads and starts.
// Rows past the filled ones are only walked with zero words per row. A
// local model of the selection predicts every pick, and each result item is
// checked field by field against it. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_max_hamming_basis_selector_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mhbs_pkg::*;

  localparam int MAX_ROWS  = MAX_ROWS_DEF;
  localparam int MAX_WORDS = MAX_WORDS_DEF;
  localparam int MAX_BASIS = MAX_BASIS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 40;
  // Rows whose words are all written before any start
  localparam int FILL_ROWS     = 12;
  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic        op;
    logic [7:0]  row;
    logic [1:0]  word;
    logic [63:0] data;
    logic [7:0]  first;
  } req_t;

  typedef struct packed {
    logic [7:0] idx;
    logic [3:0] pos;
    logic       fin;
    logic       err;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode;
  logic [7:0]  row_index;
  logic [1:0]  word_index;
  logic [63:0] row_word;
  logic [7:0]  first_index;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  selected_index;
  logic [3:0]  position;
  logic        last;
  logic        error;

  req_t cur_req = '0;

  assign mode        = cur_req.op;
  assign row_index   = cur_req.row;
  assign word_index  = cur_req.word;
  assign row_word    = cur_req.data;
  assign first_index = cur_req.first;

  max_hamming_basis_selector_core uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .row_index      (row_index),
    .word_index     (word_index),
    .row_word       (row_word),
    .first_index    (first_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .selected_index (selected_index),
    .position       (position),
    .last           (last),
    .error          (error)
  );

  // Mirror of the row store and selection state
  logic [63:0] row_mem [MAX_ROWS*MAX_WORDS];
  bit          chosen  [MAX_ROWS];
  int          dist_sum[MAX_ROWS];
  logic [8:0]  cfg_rows  = NUM_ROWS_RST;
  logic [4:0]  cfg_basis = NUM_BASIS_RST;
  logic [2:0]  cfg_words = WORDS_RST;

  req_t  pending_reqs[$];
  pick_t expected_picks[$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  cycle_limit    = 100000;
  int  random_items   = 0;
  bit  no_gaps        = 1'b0;
  int  gap_left       = 0;
  int  stall_left     = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = row_mem[$urandom_range(0, MAX_ROWS*MAX_WORDS-1)];
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Greedy farthest-first selection; append the picks one start produces
  function automatic void predict_picks(input logic [7:0] first);
    int    rows, words, nb, last_pick, best, best_sum, i, k, w, d;
    bit    found;
    pick_t p;
    rows  = (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
    words = (cfg_words > MAX_WORDS) ? MAX_WORDS : int'(cfg_words);
    nb    = cfg_basis;
    if (first >= rows || nb == 0 || nb > rows || nb > MAX_BASIS) begin
      p = '{idx: 8'd0, pos: 4'd0, fin: 1'b1, err: 1'b1};
      expected_picks = {expected_picks, p};
      return;
    end
    for (i = 0; i < MAX_ROWS; i++) begin
      chosen[i]   = 1'b0;
      dist_sum[i] = 0;
    end
    chosen[first] = 1'b1;
    last_pick = first;
    p = '{idx: first, pos: 4'd0, fin: (nb == 1), err: 1'b0};
    expected_picks = {expected_picks, p};
    for (k = 1; k < nb; k++) begin
      found    = 1'b0;
      best     = 0;
      best_sum = 0;
      for (i = 0; i < rows; i++) begin
        if (!chosen[i]) begin
          d = 0;
          for (w = 0; w < words; w++)
            d += $countones(row_mem[i*MAX_WORDS+w] ^ row_mem[last_pick*MAX_WORDS+w]);
          dist_sum[i] += d;
          // strict compare keeps the lowest index on ties
          if (!found || dist_sum[i] > best_sum) begin
            found    = 1'b1;
            best     = i;
            best_sum = dist_sum[i];
          end
        end
      end
      chosen[best] = 1'b1;
      last_pick = best;
      p.idx = best[7:0];
      p.pos = k[3:0];
      p.fin = (k + 1 == nb);
      p.err = 1'b0;
      expected_picks = {expected_picks, p};
    end
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_load(input int r, input int w, input logic [63:0] d);
    req_t q;
    q = '{op: MODE_LOAD, row: r[7:0], word: w[1:0], data: d,
          first: 8'($urandom_range(0, 255))};
    pending_reqs = {pending_reqs, q};
    cycle_limit += 4 * 45;
  endtask

  task automatic queue_start(input int f);
    req_t q;
    int   rows_e, words_e, nb_e;
    q = '{op: MODE_START, row: 8'($urandom_range(0, 255)), word: 2'($urandom_range(0, 3)),
          data: {$urandom, $urandom}, first: f[7:0]};
    pending_reqs = {pending_reqs, q};
    rows_e  = (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
    words_e = (cfg_words > MAX_WORDS) ? MAX_WORDS : int'(cfg_words);
    nb_e    = (cfg_basis > MAX_BASIS) ? MAX_BASIS : int'(cfg_basis);
    cycle_limit += 4 * (60 + (nb_e + 1) * (rows_e * (3 * words_e + 7) + 60));
  endtask

  // Wait until every item is taken and every result is back, then settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_picks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_NUM_ROWS:  cfg_rows  = val[8:0];
      REG_NUM_BASIS: cfg_basis = val[4:0];
      REG_WORDS:     cfg_words = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int rows, input int nb, input int words);
    wait_drained();
    write_reg(REG_NUM_ROWS, rows[8:0]);
    write_reg(REG_NUM_BASIS, nb[8:0]);
    write_reg(REG_WORDS, words[8:0]);
  endtask

  // Drive input items; predict at the edge where each one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (cur_req.op == MODE_LOAD)
          row_mem[{cur_req.row, cur_req.word}] = cur_req.data;
        else
          predict_picks(cur_req.first);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          gap_left <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check result items against the oldest predicted pick; stall at random
  always @(posedge clk) begin : result_check
    pick_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_picks.size() == 0) begin
          flag_mismatch("unexpected result item, selected_index", selected_index, -1);
        end else begin
          want = expected_picks.pop_front();
          if (selected_index !== want.idx)
            flag_mismatch("selected_index", selected_index, want.idx);
          if (position !== want.pos)
            flag_mismatch("position", position, want.pos);
          if (last !== want.fin)
            flag_mismatch("last", last, want.fin);
          if (error !== want.err)
            flag_mismatch("error", error, want.err);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left <= gap_len();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int r, w, pick, rows, rows_used, nb, words, nseq, nloads, s, l;

    for (r = 0; r < MAX_ROWS*MAX_WORDS; r++) row_mem[r] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Fill every word of the low rows so no start reads unwritten data
    for (r = 0; r < FILL_ROWS; r++)
      for (w = 0; w < MAX_WORDS; w++)
        queue_load(r, w, (r == 0) ? 64'd0 : (r == FILL_ROWS - 1) ? '1 : rand_word());

    // Reset row and pick counts (256 rows, 16 picks) with no words to read
    wait_drained();
    write_reg(REG_WORDS, 9'd0);
    queue_start(0);

    // Small set with tied rows; last valid index and first bad index
    set_config(8, 8, 1);
    queue_load(2, 0, 64'hF0F0_F0F0_F0F0_F0F0);
    queue_load(3, 0, 64'hF0F0_F0F0_F0F0_F0F0);
    queue_load(4, 0, 64'hF0F0_F0F0_F0F0_F0F0);
    queue_start(7);
    queue_start(8);

    // Single pick, zero picks, more picks than rows
    set_config(8, 1, 1);
    queue_start(3);
    set_config(8, 0, 1);
    queue_start(0);
    set_config(8, 9, 1);
    queue_start(0);

    // No rows in use
    set_config(0, 4, 2);
    queue_start(0);

    // Rows past capacity; too many basis rows; words past capacity
    set_config(511, 17, 7);
    queue_start(255);
    set_config(300, 3, 0);
    queue_start(255);
    set_config(FILL_ROWS, 3, 7);
    queue_start(FILL_ROWS - 1);

    // Zero words: all distances zero, picks go by lowest index
    set_config(10, 5, 0);
    queue_start(4);

    // One row, one pick; a write to the unused index changes nothing
    set_config(1, 1, 2);
    write_reg(REG_SPARE, 9'h1FF);
    queue_start(0);

    // Random phases of loads followed by a start
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)       rows = 0;
      else if (pick < 85) rows = $urandom_range(1, FILL_ROWS);
      else if (pick < 94) rows = $urandom_range(FILL_ROWS + 1, 64);
      else                rows = $urandom_range(256, 511);
      rows_used = (rows > MAX_ROWS) ? MAX_ROWS : rows;
      if (rows_used > 64)
        nb = $urandom_range(1, 4);
      else if (rows_used != 0 && $urandom_range(0, 99) < 85)
        nb = $urandom_range(1, (rows_used < MAX_BASIS) ? rows_used : MAX_BASIS);
      else
        nb = $urandom_range(0, 31);
      if ($urandom_range(0, 99) < 85) begin
        words = $urandom_range(1, 4);
      end else begin
        words = $urandom_range(0, 3);
        words = (words == 0) ? 0 : words + 4;
      end
      // Rows past the filled ones are only walked with no words to read
      if (rows_used > FILL_ROWS) words = 0;
      set_config(rows, nb, words);
      no_gaps = ($urandom_range(0, 3) == 0);

      nseq = $urandom_range(1, 3);
      for (s = 0; s < nseq; s++) begin
        nloads = $urandom_range(0, 6);
        for (l = 0; l < nloads; l++) begin
          if (rows_used != 0 && $urandom_range(0, 9) != 0)
            r = $urandom_range(0, rows_used - 1);
          else
            r = $urandom_range(0, MAX_ROWS - 1);
          queue_load(r, $urandom_range(0, MAX_WORDS - 1), rand_word());
        end
        if (rows_used != 0 && $urandom_range(0, 99) < 85)
          queue_start($urandom_range(0, rows_used - 1));
        else
          queue_start($urandom_range(0, 255));
        random_items += nloads + 1;
      end
    end

    wait_drained();
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
